@@ rtl/core/npc_pkg.sv @@
package npc_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int IDX_W = $clog2(PALETTE_ENTRIES);
	localparam int CHAN_W = 8;
	localparam int COLOUR_W = 3 * CHAN_W;
	localparam int SQ_W = 2 * CHAN_W;
	// three squares of 8-bit differences, at most 195075
	localparam int DIST_W = SQ_W + 2;
	localparam int ENTRY_IDX_W = 8;
	localparam int OUT_IDX_W = 8;
	localparam int WIDE_IDX_W = IDX_W + ENTRY_IDX_W;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} npc_state_t;

	typedef struct packed {
		logic             wr_en;
		logic             query_load;
		logic             issue;
		logic             first;
		logic             last;
		logic [IDX_W-1:0] addr;
		logic             out_load;
	} npc_cmd_t;

	typedef struct packed {
		logic best_done;
		logic out_free;
	} npc_stat_t;

endpackage

@@ rtl/core/npc_ram.sv @@
module npc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

@@ rtl/core/npc_ctrl.sv @@
module npc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_cmd,
	output logic              in_ready,
	input  npc_pkg::npc_stat_t stat,
	output npc_pkg::npc_cmd_t  cmd
);

	import npc_pkg::*;

	npc_state_t state_q, state_d;
	logic [IDX_W-1:0] cnt_q, cnt_d;
	logic last;
	logic accept;

	assign last = (cnt_q == IDX_W'(PALETTE_ENTRIES - 1));
	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd = '0;
		cmd.addr = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				cnt_d = '0;
				if (accept) begin
					if (in_cmd == CMD_QUERY) begin
						cmd.query_load = 1'b1;
						state_d = ST_SCAN;
					end else begin
						cmd.wr_en = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				// one palette read issued per cycle
				cmd.issue = 1'b1;
				cmd.first = (cnt_q == '0);
				cmd.last = last;
				if (last) begin
					cnt_d = '0;
					state_d = ST_FINISH;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_FINISH: begin
				if (stat.best_done && stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/core/npc_datapath.sv @@
module npc_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  npc_pkg::npc_cmd_t              cmd,
	output npc_pkg::npc_stat_t             stat,
	input  logic [npc_pkg::ENTRY_IDX_W-1:0] in_entry_index,
	input  logic [npc_pkg::CHAN_W-1:0]      in_red,
	input  logic [npc_pkg::CHAN_W-1:0]      in_green,
	input  logic [npc_pkg::CHAN_W-1:0]      in_blue,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [npc_pkg::OUT_IDX_W-1:0]  out_index
);

	import npc_pkg::*;

	logic [WIDE_IDX_W-1:0] wide_wr_idx;
	logic                  wr_ok;
	logic [COLOUR_W-1:0]   rd_data;

	logic [COLOUR_W-1:0] query_q;

	logic             vld_s1, first_s1, last_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             vld_s2, first_s2, last_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [SQ_W-1:0]  sq_r_s2, sq_g_s2, sq_b_s2;

	logic [CHAN_W-1:0] dr, dg, db;
	logic [DIST_W-1:0] dist_sum;
	logic              take;

	logic [DIST_W-1:0] best_dist_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic              best_done_q;
	logic              out_valid_q;
	logic [OUT_IDX_W-1:0] out_index_q;
	logic [WIDE_IDX_W-1:0] wide_best;

	function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
	                                               input logic [CHAN_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	// writes past the palette are dropped
	assign wide_wr_idx = {{IDX_W{1'b0}}, in_entry_index};
	assign wr_ok = cmd.wr_en && (wide_wr_idx < WIDE_IDX_W'(PALETTE_ENTRIES));

	npc_ram #(
		.WIDTH(COLOUR_W),
		.DEPTH(PALETTE_ENTRIES)
	) u_palette (
		.clk    (clk),
		.wr_en  (wr_ok),
		.wr_addr(wide_wr_idx[IDX_W-1:0]),
		.wr_data({in_red, in_green, in_blue}),
		.rd_addr(cmd.addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.query_load) begin
			query_q <= {in_red, in_green, in_blue};
		end
	end

	// s1: ram data lands, s2: squares, then sum and compare into best
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
		end
	end

	assign dr = abs_diff(rd_data[3*CHAN_W-1:2*CHAN_W], query_q[3*CHAN_W-1:2*CHAN_W]);
	assign dg = abs_diff(rd_data[2*CHAN_W-1:CHAN_W], query_q[2*CHAN_W-1:CHAN_W]);
	assign db = abs_diff(rd_data[CHAN_W-1:0], query_q[CHAN_W-1:0]);

	always_ff @(posedge clk) begin
		idx_s1 <= cmd.addr;
		first_s1 <= cmd.first;
		last_s1 <= cmd.last;
		idx_s2 <= idx_s1;
		first_s2 <= first_s1;
		last_s2 <= last_s1;
		sq_r_s2 <= SQ_W'(dr) * SQ_W'(dr);
		sq_g_s2 <= SQ_W'(dg) * SQ_W'(dg);
		sq_b_s2 <= SQ_W'(db) * SQ_W'(db);
	end

	assign dist_sum = DIST_W'(sq_r_s2) + DIST_W'(sq_g_s2) + DIST_W'(sq_b_s2);
	// strict less-than keeps the lowest index on ties
	assign take = vld_s2 && (first_s2 || (dist_sum < best_dist_q));

	always_ff @(posedge clk) begin
		if (take) begin
			best_dist_q <= dist_sum;
			best_idx_q <= idx_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_done_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load || cmd.query_load) begin
				best_done_q <= 1'b0;
			end else if (vld_s2 && last_s2) begin
				best_done_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign wide_best = {{ENTRY_IDX_W{1'b0}}, best_idx_q};

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_index_q <= wide_best[OUT_IDX_W-1:0];
		end
	end

	assign stat.best_done = best_done_q;
	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_index = out_index_q;

endmodule

@@ rtl/core/nearest_palette_colour_unit.sv @@
// nearest palette colour unit: holds a palette of PALETTE_ENTRIES (256) rgb colours
// in a single-port-write, registered-read ram and answers queries with the index of
// the entry whose squared euclidean distance to the query colour is least, lowest
// index on ties. a word with tuser = 0 writes one palette entry and gives no result;
// a word with tuser = 1 is a query and gives one result word. writes are taken back
// to back. before a query's result is loaded into the output register, the scan
// reads one entry a cycle from the palette ram's single read port, followed by the
// ram read, square and compare stages. the input is held off while a query runs; a
// finished result waits in the output register while further words are taken. the
// palette powers up undefined and every entry must be written before the first query
module nearest_palette_colour_unit (
	input  logic        clk,
	input  logic        arst_n,
	// input word stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] entry_index, [15:8] red, [23:16] green, [31:24] blue
	input  logic [31:0] s_axis_tdata,
	// [0] cmd: 0 write entry, 1 query
	input  logic [0:0]  s_axis_tuser,
	// result word stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] nearest_index
	output logic [7:0]  m_axis_tdata
);

	import npc_pkg::*;

	npc_cmd_t  cmd;
	npc_stat_t stat;

	// sequencer: accepts words, steps the scan address, hands off the result
	npc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_cmd  (s_axis_tuser[0]),
		.in_ready(s_axis_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// palette ram, distance pipeline, best tracker and output register
	npc_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_entry_index(s_axis_tdata[7:0]),
		.in_red        (s_axis_tdata[15:8]),
		.in_green      (s_axis_tdata[23:16]),
		.in_blue       (s_axis_tdata[31:24]),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_index     (m_axis_tdata)
	);

endmodule

@@ dv/nearest_palette_colour_unit_tb.sv @@
`timescale 1ns / 1ps

module nearest_palette_colour_unit_tb;
	import npc_pkg::*;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #1 clk = ~clk;

	// input word stream, idle from time zero
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// [7:0] entry_index, [15:8] red, [23:16] green, [31:24] blue
	logic [31:0] s_axis_tdata = '0;
	// [0] cmd: write entry or query
	logic [0:0]  s_axis_tuser = CMD_WRITE;

	// result word stream
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [7:0] nearest_index
	logic [7:0]  m_axis_tdata;

	nearest_palette_colour_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// shadow palette, {red, green, blue} per entry, updated as write words are taken
	logic [COLOUR_W-1:0] palette_shadow [PALETTE_ENTRIES];
	// nearest indexes still owed by the block, oldest first
	logic [OUT_IDX_W-1:0] pending_nearest [$];

	// percent chance per cycle of the sender holding back and of the receiver stalling
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned fail_count = 0;

	// squared difference of one 8-bit channel
	function automatic logic [SQ_W-1:0] channel_sq(input logic [CHAN_W-1:0] a,
			input logic [CHAN_W-1:0] b);
		logic [CHAN_W-1:0] diff;
		diff = (a >= b) ? a - b : b - a;
		return SQ_W'(diff) * SQ_W'(diff);
	endfunction

	// full scan of the shadow palette, only a strictly closer entry takes over
	// so equal distances keep the lowest index
	function automatic logic [OUT_IDX_W-1:0] closest_entry(input logic [CHAN_W-1:0] red,
			input logic [CHAN_W-1:0] green, input logic [CHAN_W-1:0] blue);
		logic [DIST_W-1:0] best_dist;
		logic [DIST_W-1:0] dist_sum;
		int best_idx;
		best_idx = 0;
		best_dist = '1;
		for (int i = 0; i < PALETTE_ENTRIES; i++) begin
			dist_sum = DIST_W'(channel_sq(red, palette_shadow[IDX_W'(i)][23:16]))
				+ DIST_W'(channel_sq(green, palette_shadow[IDX_W'(i)][15:8]))
				+ DIST_W'(channel_sq(blue, palette_shadow[IDX_W'(i)][7:0]));
			if (i == 0 || dist_sum < best_dist) begin
				best_dist = dist_sum;
				best_idx = i;
			end
		end
		return OUT_IDX_W'(best_idx);
	endfunction

	// offer one word; tvalid is left high after the handshake so back-to-back words
	// need no second assignment in the same step, a gap lowers it first
	task automatic send_word(input logic cmd, input logic [7:0] entry_idx,
			input logic [CHAN_W-1:0] red, input logic [CHAN_W-1:0] green,
			input logic [CHAN_W-1:0] blue);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {blue, green, red, entry_idx};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		// word taken at this edge, update the shadow state in order
		if (cmd == CMD_WRITE) begin
			if (int'(entry_idx) < PALETTE_ENTRIES)
				palette_shadow[entry_idx] = {red, green, blue};
		end else begin
			pending_nearest.push_back(closest_entry(red, green, blue));
		end
	endtask

	// drop tvalid and hold off until every owed result has come back
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_nearest.size() != 0)
			@(posedge clk);
	endtask

	// receiver side: random back-pressure and in-order compare of each result word
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_nearest.size() == 0) begin
				$error("unexpected result word: nearest_index actual %0d", m_axis_tdata);
				fail_count++;
			end else begin
				automatic logic [OUT_IDX_W-1:0] want = pending_nearest.pop_front();
				if (m_axis_tdata !== want) begin
					$error("nearest_index mismatch: expected %0d actual %0d",
						want, m_axis_tdata);
					fail_count++;
				end
			end
		end
	end

	// every entry has to hold a known colour before the first query
	task automatic test_palette_load();
		logic [COLOUR_W-1:0] colour;
		for (int i = 0; i < PALETTE_ENTRIES; i++) begin
			colour = COLOUR_W'($urandom);
			// sprinkle a few repeats so ties show up early
			if (i > 0 && $urandom_range(9) == 0)
				colour = palette_shadow[IDX_W'($urandom_range(i - 1))];
			send_word(CMD_WRITE, 8'(i), colour[23:16], colour[15:8], colour[7:0]);
		end
	endtask

	// pure black and white at both ends of the table, then queries at the corners
	// of the colour cube, entry_index of a query set to both extremes
	task automatic test_colour_extremes();
		send_word(CMD_WRITE, 8'h00, 8'h00, 8'h00, 8'h00);
		send_word(CMD_WRITE, 8'hff, 8'hff, 8'hff, 8'hff);
		send_word(CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'h00);
		send_word(CMD_QUERY, 8'hff, 8'hff, 8'hff, 8'hff);
		send_word(CMD_QUERY, 8'h5a, 8'hff, 8'h00, 8'h00);
		send_word(CMD_QUERY, 8'ha5, 8'h00, 8'hff, 8'h00);
		send_word(CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'hff);
		send_word(CMD_QUERY, 8'hff, 8'hff, 8'hff, 8'h00);
	endtask

	// equal distances must resolve to the lower index
	task automatic test_tie_breaking();
		// same colour in two entries, exact hit on both
		send_word(CMD_WRITE, 8'd7,   8'h12, 8'h34, 8'h56);
		send_word(CMD_WRITE, 8'd250, 8'h12, 8'h34, 8'h56);
		send_word(CMD_QUERY, 8'd250, 8'h12, 8'h34, 8'h56);
		// query halfway between two neighbours, distance one to each
		send_word(CMD_WRITE, 8'd10, 8'd100, 8'd100, 8'd100);
		send_word(CMD_WRITE, 8'd11, 8'd102, 8'd100, 8'd100);
		send_word(CMD_QUERY, 8'd11, 8'd101, 8'd100, 8'd100);
		// overwrite the lower copy, the higher one must win now
		send_word(CMD_WRITE, 8'd7, 8'hed, 8'hcb, 8'ha9);
		send_word(CMD_QUERY, 8'd7, 8'h12, 8'h34, 8'h56);
		drain_results();
	endtask

	// mixed writes and queries under one idle/stall profile, with a full
	// drain halfway through and at the end
	task automatic test_random_traffic(input int unsigned num_words,
			input int unsigned idle_pct, input int unsigned stall_pct);
		int unsigned pick;
		logic [COLOUR_W-1:0] colour;
		logic [7:0] entry_idx;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int unsigned n = 0; n < num_words; n++) begin
			pick = $urandom_range(99);
			entry_idx = 8'($urandom);
			colour = COLOUR_W'($urandom);
			if (pick < 15) begin
				// exact hit on some entry
				colour = palette_shadow[IDX_W'($urandom_range(PALETTE_ENTRIES - 1))];
				send_word(CMD_QUERY, entry_idx, colour[23:16], colour[15:8], colour[7:0]);
			end else if (pick < 45) begin
				send_word(CMD_QUERY, entry_idx, colour[23:16], colour[15:8], colour[7:0]);
			end else begin
				// copies of live colours make ties, cube corners push the distances up
				if (pick < 60)
					colour = palette_shadow[IDX_W'($urandom_range(PALETTE_ENTRIES - 1))];
				else if (pick >= 95)
					colour = {{8{colour[2]}}, {8{colour[1]}}, {8{colour[0]}}};
				send_word(CMD_WRITE, entry_idx, colour[23:16], colour[15:8], colour[7:0]);
			end
			if (n == num_words / 2)
				drain_results();
		end
		drain_results();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_palette_load();
		test_colour_extremes();
		test_tie_breaking();
		// no idling, sender mostly idle, receiver mostly stalled, both now and then
		test_random_traffic(110, 0, 0);
		test_random_traffic(110, 81, 0);
		test_random_traffic(110, 0, 81);
		test_random_traffic(110, 23, 23);

		// nothing owed any more, give a stray word a full scan time to show up
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (PALETTE_ENTRIES + 40) @(posedge clk);
		if (pending_nearest.size() != 0) begin
			$error("%0d nearest_index results never arrived", pending_nearest.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// watchdog, far beyond a slow but correct run
	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
